/* design/wsp_pkg.sv */
package wsp_pkg;

  // Default number of fraction bits of the fixed-point values.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Input item opcodes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_VISIBLE   = 2'd0;
  localparam logic [1:0] ST_BEHIND    = 2'd1;
  localparam logic [1:0] ST_OFFSCREEN = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;

  // Reset values of the viewport size.
  localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1920;
  localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd1080;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } wsp_ctl_t;

endpackage

/* design/wsp_in_if.sv */
interface wsp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  modport source(output valid, opcode, coef_index, coef_value, world_x, world_y, world_z,
                 input ready);
  modport sink(input valid, opcode, coef_index, coef_value, world_x, world_y, world_z,
               output ready);
endinterface

/* design/wsp_out_if.sv */
interface wsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] screen_x;
  logic [31:0] screen_y;

  modport source(output valid, status, screen_x, screen_y, input ready);
  modport sink(input valid, status, screen_x, screen_y, output ready);
endinterface

/* design/wsp_cfg_if.sv */
interface wsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/wsp_xform.sv */
module wsp_xform import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               load_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic               proj_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic signed [31:0] world_z_i,
  output wsp_ctl_t           ctl_o,
  output logic signed [31:0] clip_x_o,
  output logic signed [31:0] clip_y_o,
  output logic signed [31:0] clip_w_o
);

  localparam logic signed [66:0] MAX32 = 67'sh7FFFFFFF;
  localparam logic signed [66:0] MIN32 = -67'sh80000000;
  // Matrix columns that give clip x, y and w.
  localparam int COL [3] = '{0, 1, 3};

  logic signed [31:0] coef_q [16];
  logic signed [31:0] pt [3];
  logic signed [63:0] prod_d [3][3];
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] bias_q [3];
  logic               va_q;
  logic               vb_q;
  logic signed [65:0] sum [3];
  logic signed [65:0] sum_sh [3];
  logic signed [66:0] tot [3];
  logic signed [31:0] clip_d [3];
  logic signed [31:0] clip_q [3];

  // Coefficient store, written by load items.
  always_ff @(posedge clk_i) begin
    if (en_i && load_i) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Stage A: the nine products.
  always_comb begin
    pt[0] = world_x_i;
    pt[1] = world_y_i;
    pt[2] = world_z_i;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        prod_d[k][r] = pt[r] * coef_q[r*4 + COL[k]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      for (int k = 0; k < 3; k++) begin
        bias_q[k] <= coef_q[12 + COL[k]];
      end
    end
  end

  // Stage B: sum, floor to the fraction width, add row three, saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]    = prod_q[k][0] + prod_q[k][1] + prod_q[k][2];
      sum_sh[k] = sum[k] >>> FRAC_BITS;
      tot[k]    = sum_sh[k] + bias_q[k];
      if (tot[k] > MAX32) begin
        clip_d[k] = 32'sh7FFFFFFF;
      end else if (tot[k] < MIN32) begin
        clip_d[k] = 32'sh80000000;
      end else begin
        clip_d[k] = tot[k][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clip_q <= clip_d;
    end
  end

  // Valid bits of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= proj_i;
      vb_q <= va_q;
    end
  end

  assign ctl_o.valid  = vb_q;
  assign ctl_o.status = ST_VISIBLE;
  assign clip_x_o     = clip_q[0];
  assign clip_y_o     = clip_q[1];
  assign clip_w_o     = clip_q[2];

endmodule

/* design/wsp_div.sv */
module wsp_div import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  wsp_ctl_t             ctl_i,
  input  logic signed [31:0]   clip_x_i,
  input  logic signed [31:0]   clip_y_i,
  input  logic signed [31:0]   clip_w_i,
  output wsp_ctl_t             ctl_o,
  output logic [FRAC_BITS:0]   quo_x_o,
  output logic [FRAC_BITS:0]   quo_y_o,
  output logic                 neg_x_o,
  output logic                 neg_y_o
);

  localparam int unsigned NS    = FRAC_BITS + 1;
  localparam int          WMR   = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int          WMIN  = (WMR < 1) ? 1 : WMR;
  localparam logic signed [31:0] W_MIN = 32'(WMIN);

  logic signed [32:0] cx, cy, cw, mcw;
  logic               behind, offscr;
  logic [32:0]        ax, ay;
  wsp_ctl_t           c_ctl_d;

  wsp_ctl_t    c_ctl_q;
  logic [32:0] c_rx_q, c_ry_q;
  logic [31:0] c_d_q;
  logic        c_nx_q, c_ny_q;

  wsp_ctl_t     s_ctl_q [NS];
  logic [32:0]  s_rx_q  [NS];
  logic [32:0]  s_ry_q  [NS];
  logic [31:0]  s_d_q   [NS];
  logic [NS-1:0] s_qx_q [NS];
  logic [NS-1:0] s_qy_q [NS];
  logic         s_nx_q  [NS];
  logic         s_ny_q  [NS];

  // Classify: behind the camera, off screen, or visible.
  always_comb begin
    cx     = clip_x_i;
    cy     = clip_y_i;
    cw     = clip_w_i;
    mcw    = -cw;
    behind = clip_w_i < W_MIN;
    offscr = (cx < mcw) || (cx > cw) || (cy < mcw) || (cy > cw);
    ax     = clip_x_i[31] ? -cx : cx;
    ay     = clip_y_i[31] ? -cy : cy;
    c_ctl_d.valid = ctl_i.valid;
    if (behind) begin
      c_ctl_d.status = ST_BEHIND;
    end else if (offscr) begin
      c_ctl_d.status = ST_OFFSCREEN;
    end else begin
      c_ctl_d.status = ST_VISIBLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_ctl_q <= '0;
    end else if (en_i) begin
      c_ctl_q <= c_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_rx_q <= ax;
      c_ry_q <= ay;
      c_d_q  <= clip_w_i[31:0];
      c_nx_q <= clip_x_i[31];
      c_ny_q <= clip_y_i[31];
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    wsp_ctl_t      ctl_in;
    logic [32:0]   rx_in, ry_in;
    logic [31:0]   d_in;
    logic [NS-1:0] qx_in, qy_in;
    logic          nx_in, ny_in;
    logic          gx, gy;
    logic [32:0]   rx_n, ry_n;

    if (s == 0) begin : g_first
      assign ctl_in = c_ctl_q;
      assign rx_in  = c_rx_q;
      assign ry_in  = c_ry_q;
      assign d_in   = c_d_q;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign nx_in  = c_nx_q;
      assign ny_in  = c_ny_q;
    end else begin : g_next
      assign ctl_in = s_ctl_q[s-1];
      assign rx_in  = s_rx_q[s-1];
      assign ry_in  = s_ry_q[s-1];
      assign d_in   = s_d_q[s-1];
      assign qx_in  = s_qx_q[s-1];
      assign qy_in  = s_qy_q[s-1];
      assign nx_in  = s_nx_q[s-1];
      assign ny_in  = s_ny_q[s-1];
    end

    always_comb begin
      gx   = rx_in >= {1'b0, d_in};
      gy   = ry_in >= {1'b0, d_in};
      rx_n = gx ? (rx_in - {1'b0, d_in}) : rx_in;
      ry_n = gy ? (ry_in - {1'b0, d_in}) : ry_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_ctl_q[s] <= '0;
      end else if (en_i) begin
        s_ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_rx_q[s] <= {rx_n[31:0], 1'b0};
        s_ry_q[s] <= {ry_n[31:0], 1'b0};
        s_d_q[s]  <= d_in;
        s_qx_q[s] <= {qx_in[NS-1:0] << 1} | NS'(gx);
        s_qy_q[s] <= {qy_in[NS-1:0] << 1} | NS'(gy);
        s_nx_q[s] <= nx_in;
        s_ny_q[s] <= ny_in;
      end
    end
  end

  assign ctl_o   = s_ctl_q[NS-1];
  assign quo_x_o = s_qx_q[NS-1];
  assign quo_y_o = s_qy_q[NS-1];
  assign neg_x_o = s_nx_q[NS-1];
  assign neg_y_o = s_ny_q[NS-1];

endmodule

/* design/wsp_view.sv */
module wsp_view import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  wsp_ctl_t           ctl_i,
  input  logic [FRAC_BITS:0] quo_x_i,
  input  logic [FRAC_BITS:0] quo_y_i,
  input  logic               neg_x_i,
  input  logic               neg_y_i,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  output wsp_ctl_t           ctl_o,
  output logic [31:0]        screen_x_o,
  output logic [31:0]        screen_y_o
);

  localparam int unsigned AW = FRAC_BITS + 2;
  localparam int unsigned PW = AW + 16;
  localparam int unsigned SW = (PW - 1 > 33) ? PW - 1 : 33;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic [AW-1:0] ax, ay;
  logic [PW-1:0] px_q, py_q;
  wsp_ctl_t      m_ctl_q;
  logic [SW-1:0] hx, hy;
  logic [31:0]   sx_d, sy_d;
  wsp_ctl_t      o_ctl_q;
  logic [31:0]   sx_q, sy_q;

  // Shift ndc from [-1,1] to [0,2], y flipped, and scale by the viewport.
  always_comb begin
    ax = neg_x_i ? (ONE - AW'(quo_x_i)) : (ONE + AW'(quo_x_i));
    ay = neg_y_i ? (ONE + AW'(quo_y_i)) : (ONE - AW'(quo_y_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= PW'(ax) * PW'(width_i);
      py_q <= PW'(ay) * PW'(height_i);
    end
  end

  // Halve, saturate, and clear the coordinates of points not visible.
  always_comb begin
    hx = SW'(px_q >> 1);
    hy = SW'(py_q >> 1);
    sx_d = (hx[SW-1:32] != '0) ? 32'hFFFFFFFF : hx[31:0];
    sy_d = (hy[SW-1:32] != '0) ? 32'hFFFFFFFF : hy[31:0];
    if (m_ctl_q.status != ST_VISIBLE) begin
      sx_d = '0;
      sy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ctl_q <= '0;
      o_ctl_q <= '0;
    end else if (en_i) begin
      m_ctl_q <= ctl_i;
      o_ctl_q <= m_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  assign ctl_o      = o_ctl_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

/* design/world_to_screen_projection_top.sv */
// World-to-screen projection of 3D points to viewport pixels.
// The input channel carries items of two kinds. A load item writes one
// coefficient of the 4x4 view-projection matrix and gives no result. A project
// item multiplies (x,y,z,1) by the matrix and gives one result item: a status
// (visible, behind camera, off screen) and the pixel position in Q16.16.
// The configuration channel sets the viewport width and height; it is always
// ready and should be written only while no item is in flight.
// The pipeline takes one item per cycle while no result is held off. A project
// item passes two stages of matrix products and sums, one classify stage, one
// stage per quotient bit of the two dividers, and two viewport stages before it
// reaches the output register.
// When the receiver holds off a waiting result, the whole pipeline freezes
// and the input is not ready, so no item is lost or repeated.
// Reset clears all valid bits and sets the viewport to 1920 by 1080. The matrix
// store is not cleared; every coefficient must be loaded before use.
module world_to_screen_projection_top import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  wsp_cfg_if.sink   cfg_i,
  wsp_in_if.sink    in_i,
  wsp_out_if.source out_o
);

  logic               en;
  logic               acc;
  logic [15:0]        width_q, height_q;
  wsp_ctl_t           x_ctl, d_ctl, o_ctl;
  logic signed [31:0] cx, cy, cw;
  logic [FRAC_BITS:0] qx, qy;
  logic               nx, ny;

  // The pipeline moves unless a result waits in the output register.
  assign en    = !o_ctl.valid || out_o.ready;
  assign acc   = in_i.valid && en;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  // Viewport size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_SCREEN_WIDTH) begin
        width_q <= cfg_i.data;
      end else if (cfg_i.index == REG_SCREEN_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  wsp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .load_i       (acc && (in_i.opcode == OP_LOAD)),
    .coef_index_i (in_i.coef_index),
    .coef_value_i (in_i.coef_value),
    .proj_i       (acc && (in_i.opcode == OP_PROJECT)),
    .world_x_i    (in_i.world_x),
    .world_y_i    (in_i.world_y),
    .world_z_i    (in_i.world_z),
    .ctl_o        (x_ctl),
    .clip_x_o     (cx),
    .clip_y_o     (cy),
    .clip_w_o     (cw)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (x_ctl),
    .clip_x_i (cx),
    .clip_y_i (cy),
    .clip_w_i (cw),
    .ctl_o    (d_ctl),
    .quo_x_o  (qx),
    .quo_y_o  (qy),
    .neg_x_o  (nx),
    .neg_y_o  (ny)
  );

  wsp_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (d_ctl),
    .quo_x_i    (qx),
    .quo_y_i    (qy),
    .neg_x_i    (nx),
    .neg_y_i    (ny),
    .width_i    (width_q),
    .height_i   (height_q),
    .ctl_o      (o_ctl),
    .screen_x_o (out_o.screen_x),
    .screen_y_o (out_o.screen_y)
  );

  assign out_o.valid  = o_ctl.valid;
  assign out_o.status = o_ctl.status;

`ifndef NO_ASSERTIONS
  // A point that is not visible reports a zero position.
  a_zero_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_VISIBLE) |->
      (out_o.screen_x == '0) && (out_o.screen_y == '0))
    else $error("hidden point with nonzero position");

  // A stalled result freezes the input side too.
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input ready while result stalled");

  // No result comes out right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_o.valid)
    else $error("result valid right after reset");
`endif

endmodule
